// File: design/trmag_pkg.sv
// Shared constants and types for the two-region memory access guard.
// Used by trmag_ram and two_region_memory_access_guard; no dependencies.
package trmag_pkg;

  localparam int RAM_BYTES   = 4096;
  localparam int FLASH_BYTES = 4096;

  localparam int BYTE_W = 8;
  localparam int LANES  = 4;
  localparam int LANE_W = 2;

  localparam int RAM_ROWS    = (RAM_BYTES + LANES - 1) / LANES;
  localparam int FLASH_ROWS  = (FLASH_BYTES + LANES - 1) / LANES;
  localparam int RAM_ROW_W   = $clog2(RAM_ROWS);
  localparam int FLASH_ROW_W = $clog2(FLASH_ROWS);
  localparam int RAM_OFF_W   = RAM_ROW_W + LANE_W;
  localparam int FLASH_OFF_W = FLASH_ROW_W + LANE_W;
  localparam int OFF_W       = (RAM_OFF_W > FLASH_OFF_W) ? RAM_OFF_W : FLASH_OFF_W;
  localparam int MAX_ROWS    = (RAM_ROWS > FLASH_ROWS) ? RAM_ROWS : FLASH_ROWS;
  localparam int CLR_W       = $clog2(MAX_ROWS);

  localparam int ADDR_W = 32;
  localparam int DATA_W = 32;
  localparam int LEN_W  = 13;
  localparam int SIZE_W = 3;
  localparam int CFG_W  = 32;
  localparam int IDX_W  = 2;

  // store depths at the width of the region limit compare
  localparam logic [ADDR_W:0] RAM_SPAN_MAX   = (ADDR_W+1)'(RAM_BYTES);
  localparam logic [ADDR_W:0] FLASH_SPAN_MAX = (ADDR_W+1)'(FLASH_BYTES);

  // slave tdata layout, lowest bit first: address, size_bytes, write_data
  localparam int ADDR_LSB   = 0;
  localparam int SIZE_LSB   = ADDR_LSB + ADDR_W;
  localparam int WDATA_LSB  = SIZE_LSB + SIZE_W;
  localparam int S_FIELDS_W = WDATA_LSB + DATA_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = DATA_W;

  localparam logic [SIZE_W-1:0] MAX_BEAT_BYTES = SIZE_W'(4);
  localparam logic [BYTE_W-1:0] RAM_FILL       = 8'h00;
  localparam logic [BYTE_W-1:0] FLASH_FILL     = 8'hFF;

  typedef enum logic [1:0] {
    OP_CORE_READ   = 2'd0,
    OP_CORE_WRITE  = 2'd1,
    OP_HOST_WRITE  = 2'd2,
    OP_CLEAR_ERROR = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_SKIPPED = 2'd2
  } status_t;

  typedef enum logic [IDX_W-1:0] {
    REG_RAM_BASE     = 2'd0,
    REG_RAM_LENGTH   = 2'd1,
    REG_FLASH_BASE   = 2'd2,
    REG_FLASH_LENGTH = 2'd3
  } cfg_reg_t;

endpackage

// File: design/trmag_ram.sv
// One byte lane of storage: single port, synchronous write, registered read.
// Depends on trmag_pkg for the byte width.
module trmag_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         we,
  input  logic [AW-1:0]                addr,
  input  logic [trmag_pkg::BYTE_W-1:0] wdata,
  output logic [trmag_pkg::BYTE_W-1:0] rdata
);

  logic [trmag_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: design/two_region_memory_access_guard.sv
// Top level of the two-region memory access guard: region check, byte-lane
// RAM/flash stores (trmag_ram) and the stream ports. Depends on trmag_pkg.
//
// Each item goes through these steps: accept, region and permission check, one access
// to the 4-lane byte memories, result into the output register. Items are
// handled one at a time, so these four steps set the rate unless the output
// register stays full; an unaligned access of up to 4 bytes touches each
// lane's single port once, so a single memory access is enough. A finished
// result may wait in the output register while the next item is accepted.
// After reset both stores are swept one 4-byte row per cycle (4 KiB stores,
// RAM to 0x00, flash to 0xFF) and no item is accepted until that finishes;
// configuration writes are taken at any time.
module two_region_memory_access_guard (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [trmag_pkg::IDX_W-1:0]      cfg_index,
  input  logic [trmag_pkg::CFG_W-1:0]      cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [trmag_pkg::S_TDATA_W-1:0]  s_tdata,   // address, size_bytes, write_data, zero pad
  input  logic [1:0]                       s_tuser,   // opcode
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [trmag_pkg::M_TDATA_W-1:0]  m_tdata,   // read_data
  output logic [1:0]                       m_tuser    // status
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_CHECK = 5'b00100,
    S_MEM   = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state;
  logic [trmag_pkg::CLR_W-1:0] clr_row;

  logic [trmag_pkg::ADDR_W-1:0] ram_base;
  logic [trmag_pkg::LEN_W-1:0]  ram_length;
  logic [trmag_pkg::ADDR_W-1:0] flash_base;
  logic [trmag_pkg::LEN_W-1:0]  flash_length;
  logic                         error_flag;

  // accepted item
  trmag_pkg::opcode_t           op;
  logic [trmag_pkg::ADDR_W-1:0] addr;
  logic [trmag_pkg::SIZE_W-1:0] size;
  logic [trmag_pkg::DATA_W-1:0] wdata;

  // check result
  logic                         res_rd;
  logic                         res_wr;
  logic                         res_flash;
  trmag_pkg::status_t           res_status;
  logic [trmag_pkg::OFF_W-1:0]  off;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      ram_base     <= '0;
      ram_length   <= '0;
      flash_base   <= '0;
      flash_length <= '0;
    end else if (cfg_we) begin
      case (trmag_pkg::cfg_reg_t'(cfg_index))
        trmag_pkg::REG_RAM_BASE:     ram_base     <= cfg_data[trmag_pkg::ADDR_W-1:0];
        trmag_pkg::REG_RAM_LENGTH:   ram_length   <= cfg_data[trmag_pkg::LEN_W-1:0];
        trmag_pkg::REG_FLASH_BASE:   flash_base   <= cfg_data[trmag_pkg::ADDR_W-1:0];
        trmag_pkg::REG_FLASH_LENGTH: flash_length <= cfg_data[trmag_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- region check
  logic [trmag_pkg::ADDR_W:0] end_addr;
  logic [trmag_pkg::ADDR_W:0] ram_eff;
  logic [trmag_pkg::ADDR_W:0] flash_eff;
  logic [trmag_pkg::ADDR_W:0] ram_lim;
  logic [trmag_pkg::ADDR_W:0] flash_lim;
  logic                       ram_hit;
  logic                       flash_hit;
  logic [trmag_pkg::RAM_OFF_W-1:0]   ram_off;
  logic [trmag_pkg::FLASH_OFF_W-1:0] flash_off;

  always_comb begin
    end_addr  = {1'b0, addr} + (trmag_pkg::ADDR_W+1)'(size);
    ram_eff   = ((trmag_pkg::ADDR_W+1)'(ram_length) > trmag_pkg::RAM_SPAN_MAX)
              ? trmag_pkg::RAM_SPAN_MAX : (trmag_pkg::ADDR_W+1)'(ram_length);
    flash_eff = ((trmag_pkg::ADDR_W+1)'(flash_length) > trmag_pkg::FLASH_SPAN_MAX)
              ? trmag_pkg::FLASH_SPAN_MAX : (trmag_pkg::ADDR_W+1)'(flash_length);
    ram_lim   = {1'b0, ram_base} + ram_eff;
    flash_lim = {1'b0, flash_base} + flash_eff;
    ram_hit   = (addr >= ram_base) && (end_addr <= ram_lim);
    flash_hit = (addr >= flash_base) && (end_addr <= flash_lim);
    // low bits of the difference are exact when the access is in range
    ram_off   = addr[trmag_pkg::RAM_OFF_W-1:0] - ram_base[trmag_pkg::RAM_OFF_W-1:0];
    flash_off = addr[trmag_pkg::FLASH_OFF_W-1:0] - flash_base[trmag_pkg::FLASH_OFF_W-1:0];
  end

  logic               dec_rd;
  logic               dec_wr;
  logic               dec_flash;
  logic               dec_set_err;
  logic               dec_clr_err;
  logic               size_ok;
  trmag_pkg::status_t dec_status;

  always_comb begin
    dec_rd      = 1'b0;
    dec_wr      = 1'b0;
    dec_flash   = 1'b0;
    dec_set_err = 1'b0;
    dec_clr_err = 1'b0;
    dec_status  = trmag_pkg::ST_OK;
    size_ok     = (size == 3'd1) || (size == 3'd2) || (size == 3'd4);
    case (op)
      trmag_pkg::OP_CLEAR_ERROR: begin
        dec_clr_err = 1'b1;
      end
      trmag_pkg::OP_HOST_WRITE: begin
        if (size > trmag_pkg::MAX_BEAT_BYTES) begin
          dec_status = trmag_pkg::ST_INVALID;
        end else if (size != '0) begin
          if (flash_hit) begin
            dec_wr    = 1'b1;
            dec_flash = 1'b1;
          end else if (ram_hit) begin
            dec_wr = 1'b1;
          end else begin
            dec_status = trmag_pkg::ST_INVALID;
          end
        end
      end
      default: begin
        if (error_flag) begin
          dec_status = trmag_pkg::ST_SKIPPED;
        end else if (size_ok && ram_hit) begin
          dec_rd = (op == trmag_pkg::OP_CORE_READ);
          dec_wr = (op == trmag_pkg::OP_CORE_WRITE);
        end else if (size_ok && flash_hit && op == trmag_pkg::OP_CORE_READ) begin
          dec_rd    = 1'b1;
          dec_flash = 1'b1;
        end else begin
          dec_status  = trmag_pkg::ST_INVALID;
          dec_set_err = 1'b1;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------- control
  logic clr_done;
  assign clr_done = (clr_row == trmag_pkg::CLR_W'(trmag_pkg::MAX_ROWS - 1));
  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_row    <= '0;
      error_flag <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_row <= clr_row + 1'b1;
          if (clr_done) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= S_MEM;
          if (dec_set_err) begin
            error_flag <= 1'b1;
          end else if (dec_clr_err) begin
            error_flag <= 1'b0;
          end
        end
        S_MEM: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op    <= trmag_pkg::opcode_t'(s_tuser);
      addr  <= s_tdata[trmag_pkg::ADDR_LSB +: trmag_pkg::ADDR_W];
      size  <= s_tdata[trmag_pkg::SIZE_LSB +: trmag_pkg::SIZE_W];
      wdata <= s_tdata[trmag_pkg::WDATA_LSB +: trmag_pkg::DATA_W];
    end
    if (state == S_CHECK) begin
      res_rd     <= dec_rd;
      res_wr     <= dec_wr;
      res_flash  <= dec_flash;
      res_status <= dec_status;
      off        <= dec_flash ? trmag_pkg::OFF_W'(flash_off) : trmag_pkg::OFF_W'(ram_off);
    end
  end

  // ---------------------------------------------------------------- byte lanes
  logic [trmag_pkg::LANE_W-1:0]      lane_idx  [trmag_pkg::LANES];
  logic                              lane_use  [trmag_pkg::LANES];
  logic                              lane_wrap [trmag_pkg::LANES];
  logic [trmag_pkg::BYTE_W-1:0]      lane_wd   [trmag_pkg::LANES];
  logic                              ram_en    [trmag_pkg::LANES];
  logic                              flash_en  [trmag_pkg::LANES];
  logic                              mem_we;
  logic [trmag_pkg::RAM_ROW_W-1:0]   ram_row   [trmag_pkg::LANES];
  logic [trmag_pkg::FLASH_ROW_W-1:0] flash_row [trmag_pkg::LANES];
  logic [trmag_pkg::BYTE_W-1:0]      ram_wd    [trmag_pkg::LANES];
  logic [trmag_pkg::BYTE_W-1:0]      flash_wd  [trmag_pkg::LANES];
  logic [trmag_pkg::BYTE_W-1:0]      ram_rdata [trmag_pkg::LANES];
  logic [trmag_pkg::BYTE_W-1:0]      flash_rdata [trmag_pkg::LANES];
  logic                              clr_ram;
  logic                              clr_flash;

  always_comb begin
    clr_ram   = (state == S_CLEAR) &&
                ({1'b0, clr_row} < (trmag_pkg::CLR_W+1)'(trmag_pkg::RAM_ROWS));
    clr_flash = (state == S_CLEAR) &&
                ({1'b0, clr_row} < (trmag_pkg::CLR_W+1)'(trmag_pkg::FLASH_ROWS));
    mem_we    = (state == S_CLEAR) || res_wr;
    for (int l = 0; l < trmag_pkg::LANES; l++) begin
      // byte of the beat that lands in this lane
      lane_idx[l]  = trmag_pkg::LANE_W'(l) - off[trmag_pkg::LANE_W-1:0];
      lane_use[l]  = ({1'b0, lane_idx[l]} < size);
      lane_wrap[l] = (trmag_pkg::LANE_W'(l) < off[trmag_pkg::LANE_W-1:0]);
      lane_wd[l]   = wdata[{lane_idx[l], 3'b000} +: trmag_pkg::BYTE_W];
      if (state == S_CLEAR) begin
        ram_en[l]    = clr_ram;
        flash_en[l]  = clr_flash;
        ram_row[l]   = clr_row[trmag_pkg::RAM_ROW_W-1:0];
        flash_row[l] = clr_row[trmag_pkg::FLASH_ROW_W-1:0];
        ram_wd[l]    = trmag_pkg::RAM_FILL;
        flash_wd[l]  = trmag_pkg::FLASH_FILL;
      end else begin
        ram_en[l]    = (state == S_MEM) && lane_use[l] && !res_flash && (res_rd || res_wr);
        flash_en[l]  = (state == S_MEM) && lane_use[l] && res_flash && (res_rd || res_wr);
        ram_row[l]   = off[trmag_pkg::RAM_OFF_W-1:trmag_pkg::LANE_W] +
                       trmag_pkg::RAM_ROW_W'(lane_wrap[l]);
        flash_row[l] = off[trmag_pkg::FLASH_OFF_W-1:trmag_pkg::LANE_W] +
                       trmag_pkg::FLASH_ROW_W'(lane_wrap[l]);
        ram_wd[l]    = lane_wd[l];
        flash_wd[l]  = lane_wd[l];
      end
    end
  end

  for (genvar g = 0; g < trmag_pkg::LANES; g++) begin : g_lane
    trmag_ram #(
      .DEPTH (trmag_pkg::RAM_ROWS),
      .AW    (trmag_pkg::RAM_ROW_W)
    ) u_ram (
      .clk   (clk),
      .en    (ram_en[g]),
      .we    (mem_we),
      .addr  (ram_row[g]),
      .wdata (ram_wd[g]),
      .rdata (ram_rdata[g])
    );

    trmag_ram #(
      .DEPTH (trmag_pkg::FLASH_ROWS),
      .AW    (trmag_pkg::FLASH_ROW_W)
    ) u_flash (
      .clk   (clk),
      .en    (flash_en[g]),
      .we    (mem_we),
      .addr  (flash_row[g]),
      .wdata (flash_wd[g]),
      .rdata (flash_rdata[g])
    );
  end

  // ---------------------------------------------------------------- result
  logic [trmag_pkg::DATA_W-1:0] rd_word;
  logic [trmag_pkg::LANE_W-1:0] src_lane;

  always_comb begin
    rd_word  = '0;
    src_lane = '0;
    for (int i = 0; i < trmag_pkg::LANES; i++) begin
      src_lane = off[trmag_pkg::LANE_W-1:0] + trmag_pkg::LANE_W'(i);
      if (res_rd && ((trmag_pkg::SIZE_W)'(i) < size)) begin
        rd_word[i*trmag_pkg::BYTE_W +: trmag_pkg::BYTE_W] =
          res_flash ? flash_rdata[src_lane] : ram_rdata[src_lane];
      end
    end
  end

  logic load_out;
  assign load_out = (state == S_RESP) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= rd_word;
      m_tuser <= res_status;
    end
  end

`ifndef ASSERT_OFF
  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_CHECK)
    else $error("accepted beat did not enter the check stage");

  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_RESP && m_tvalid && !m_tready |=> state == S_RESP)
    else $error("result dropped while output register is full");

  a_skip_flag: assert property (@(posedge clk) disable iff (rst)
    state == S_MEM && res_status == trmag_pkg::ST_SKIPPED |-> error_flag)
    else $error("skip reported without a sticky error");

  a_err_source: assert property (@(posedge clk) disable iff (rst)
    $rose(error_flag) |-> $past(state == S_CHECK))
    else $error("error flag set outside the check stage");
`endif

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for two_region_memory_access_guard: directed table, then random
// accesses over several region layouts, checked against a byte-level memory predictor.
// Depends on trmag_pkg and the design files; needs nothing else.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import trmag_pkg::*;

  localparam int DIR_ROWS        = 27;
  localparam int DIR_CFG_AT      = 4;     // rows before this run with the reset layout
  localparam int RAND_PHASES     = 6;
  localparam int ITEMS_PER_PHASE = 155;
  localparam int SETTLE_CYCLES   = 8;
  localparam int RX_HOLD_CYCLES  = 300;

  typedef struct packed {
    opcode_t             op;
    logic [ADDR_W-1:0]   addr;
    logic [SIZE_W-1:0]   size;
    logic [DATA_W-1:0]   wdata;
  } guard_req_t;

  typedef struct packed {
    logic [DATA_W-1:0]   rd;
    status_t             st;
  } guard_rsp_t;

  typedef struct packed {
    guard_req_t          req;
    logic                typed;
    guard_rsp_t          rsp;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata;   // address, size_bytes, write_data, zero pad
  logic [1:0]            s_tuser;   // opcode
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;   // read_data
  logic [1:0]            m_tuser;   // status

  // predictor state
  logic [7:0]            ram_img   [RAM_BYTES];
  logic [7:0]            flash_img [FLASH_BYTES];
  logic                  sticky_err;
  logic [ADDR_W-1:0]     ram_base, flash_base;
  logic [LEN_W-1:0]      ram_len, flash_len;

  guard_rsp_t            pending_results[$];
  int                    mismatch_count = 0;
  int                    tx_idle_pct = 18;
  int                    rx_idle_pct = 73;
  int                    rx_hold = 0;

  // layout for rows from DIR_CFG_AT on: RAM 0x1000 + 4 KiB, flash in the top 4 KiB
  dir_row_t dir_rows [DIR_ROWS] = '{
    // reset layout: both regions empty
    '{'{OP_CORE_READ,   32'h0000_0000, 3'd4, 32'h0},          1'b1, '{32'h0, ST_INVALID}},
    '{'{OP_CORE_READ,   32'h0000_0000, 3'd1, 32'h0},          1'b1, '{32'h0, ST_SKIPPED}},
    '{'{OP_HOST_WRITE,  32'h0000_0000, 3'd4, 32'hFFFF_FFFF},  1'b1, '{32'h0, ST_INVALID}},
    '{'{OP_CLEAR_ERROR, 32'h0000_0000, 3'd0, 32'h0},          1'b1, '{32'h0, ST_OK}},
    // fill values after reset
    '{'{OP_CORE_READ,   32'h0000_1000, 3'd4, 32'h0},          1'b1, '{32'h0, ST_OK}},
    '{'{OP_CORE_READ,   32'hFFFF_F000, 3'd4, 32'h0},          1'b1, '{32'hFFFF_FFFF, ST_OK}},
    '{'{OP_CORE_WRITE,  32'h0000_1000, 3'd4, 32'hDEAD_BEEF},  1'b1, '{32'h0, ST_OK}},
    '{'{OP_CORE_READ,   32'h0000_1001, 3'd2, 32'h0},          1'b1, '{32'h0000_ADBE, ST_OK}},
    // last RAM byte, then an access running off the end
    '{'{OP_CORE_WRITE,  32'h0000_1FFF, 3'd1, 32'hFFFF_FFFF},  1'b1, '{32'h0, ST_OK}},
    '{'{OP_CORE_READ,   32'h0000_1FFE, 3'd4, 32'h0},          1'b1, '{32'h0, ST_INVALID}},
    '{'{OP_CORE_READ,   32'h0000_1000, 3'd1, 32'h0},          1'b1, '{32'h0, ST_SKIPPED}},
    '{'{OP_CLEAR_ERROR, 32'h0000_0000, 3'd0, 32'h0},          1'b1, '{32'h0, ST_OK}},
    // flash is read-only for the core
    '{'{OP_CORE_WRITE,  32'hFFFF_F000, 3'd4, 32'h1234_5678},  1'b1, '{32'h0, ST_INVALID}},
    '{'{OP_CLEAR_ERROR, 32'h0000_0000, 3'd0, 32'h0},          1'b1, '{32'h0, ST_OK}},
    '{'{OP_CORE_READ,   32'h0000_1000, 3'd3, 32'h0},          1'b1, '{32'h0, ST_INVALID}},
    '{'{OP_CLEAR_ERROR, 32'h0000_0000, 3'd0, 32'h0},          1'b1, '{32'h0, ST_OK}},
    '{'{OP_CORE_WRITE,  32'h0000_1000, 3'd7, 32'h0},          1'b1, '{32'h0, ST_INVALID}},
    '{'{OP_CLEAR_ERROR, 32'h0000_0000, 3'd0, 32'h0},          1'b1, '{32'h0, ST_OK}},
    // host writes the very top of the address space
    '{'{OP_HOST_WRITE,  32'hFFFF_FFFC, 3'd4, 32'h1234_5678},  1'b1, '{32'h0, ST_OK}},
    '{'{OP_CORE_READ,   32'hFFFF_FFFC, 3'd4, 32'h0},          1'b1, '{32'h1234_5678, ST_OK}},
    '{'{OP_CORE_READ,   32'hFFFF_FFFE, 3'd4, 32'h0},          1'b1, '{32'h0, ST_INVALID}},
    // host path ignores the sticky error and never touches it
    '{'{OP_HOST_WRITE,  32'h0000_1000, 3'd0, 32'hFFFF_FFFF},  1'b1, '{32'h0, ST_OK}},
    '{'{OP_HOST_WRITE,  32'h0000_1000, 3'd5, 32'hFFFF_FFFF},  1'b1, '{32'h0, ST_INVALID}},
    '{'{OP_HOST_WRITE,  32'h0000_1FFD, 3'd3, 32'h00AA_BBCC},  1'b0, '{32'h0, ST_OK}},
    '{'{OP_CORE_READ,   32'h0000_1000, 3'd1, 32'h0},          1'b1, '{32'h0, ST_SKIPPED}},
    '{'{OP_CLEAR_ERROR, 32'h0000_0000, 3'd0, 32'h0},          1'b1, '{32'h0, ST_OK}},
    '{'{OP_CORE_READ,   32'h0000_1FFC, 3'd4, 32'h0},          1'b0, '{32'h0, ST_OK}}
  };

  two_region_memory_access_guard u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #10 clk = ~clk;

  // [a, a+n) inside [base, base+len) with len capped at the store depth, no 32-bit wrap
  function automatic bit region_hit(input logic [ADDR_W-1:0] base, input logic [LEN_W-1:0] len,
                                    input int unsigned depth, input logic [ADDR_W-1:0] a,
                                    input logic [SIZE_W-1:0] n, output int unsigned off);
    longint unsigned span;
    span = (len > depth) ? depth : len;
    off  = a - base;
    return (a >= base) && ({32'd0, a} + 64'(n) <= {32'd0, base} + span);
  endfunction

  function automatic guard_rsp_t predict_access(input guard_req_t r);
    guard_rsp_t  res;
    int unsigned ro, fo;
    bit          in_ram, in_flash;
    res = '{rd: '0, st: ST_OK};
    ro = 0;
    fo = 0;
    in_ram = 1'b0;
    in_flash = 1'b0;
    case (r.op)
      OP_CLEAR_ERROR: sticky_err = 1'b0;
      OP_HOST_WRITE: begin
        if (r.size > MAX_BEAT_BYTES) begin
          res.st = ST_INVALID;
        end else if (r.size != 0) begin
          // flash wins for the host
          in_flash = region_hit(flash_base, flash_len, FLASH_BYTES, r.addr, r.size, fo);
          if (!in_flash) in_ram = region_hit(ram_base, ram_len, RAM_BYTES, r.addr, r.size, ro);
          if (in_flash) begin
            for (int i = 0; i < r.size; i++) flash_img[fo + i] = r.wdata[8*i +: 8];
          end else if (in_ram) begin
            for (int i = 0; i < r.size; i++) ram_img[ro + i] = r.wdata[8*i +: 8];
          end else begin
            res.st = ST_INVALID;
          end
        end
      end
      default: begin
        if (sticky_err) begin
          res.st = ST_SKIPPED;
        end else begin
          if (r.size == 1 || r.size == 2 || r.size == 4) begin
            in_ram = region_hit(ram_base, ram_len, RAM_BYTES, r.addr, r.size, ro);
            if (!in_ram)
              in_flash = region_hit(flash_base, flash_len, FLASH_BYTES, r.addr, r.size, fo);
          end
          if (!(in_ram || in_flash) || (r.op == OP_CORE_WRITE && !in_ram)) begin
            sticky_err = 1'b1;
            res.st = ST_INVALID;
          end else if (r.op == OP_CORE_READ) begin
            for (int i = 0; i < r.size; i++)
              res.rd[8*i +: 8] = in_ram ? ram_img[ro + i] : flash_img[fo + i];
          end else begin
            for (int i = 0; i < r.size; i++) ram_img[ro + i] = r.wdata[8*i +: 8];
          end
        end
      end
    endcase
    return res;
  endfunction

  // mostly accesses aimed at or just around a region, the rest anywhere
  function automatic guard_req_t rand_access();
    guard_req_t        r;
    int unsigned       pick, span;
    logic [ADDR_W-1:0] base;
    pick = $urandom_range(99);
    r.op = (pick < 35) ? OP_CORE_READ : (pick < 60) ? OP_CORE_WRITE :
           (pick < 80) ? OP_HOST_WRITE : OP_CLEAR_ERROR;
    pick = $urandom_range(99);
    r.size = (pick < 35) ? 3'd4 : (pick < 60) ? 3'd2 : (pick < 88) ? 3'd1 :
             3'($urandom_range(7));
    r.wdata = $urandom;
    pick = $urandom_range(99);
    if (pick < 45) begin
      base = ram_base;
      span = (ram_len > RAM_BYTES) ? RAM_BYTES : ram_len;
    end else begin
      base = flash_base;
      span = (flash_len > FLASH_BYTES) ? FLASH_BYTES : flash_len;
    end
    if (pick >= 80) begin
      r.addr = $urandom;
    end else begin
      pick = $urandom_range(9);
      if (pick == 0)
        r.addr = base - 32'($urandom_range(1, 4));
      else if (pick == 1)
        r.addr = base + 32'(span) - 32'(r.size) + 32'($urandom_range(2)) - 32'd1;
      else
        r.addr = base + 32'($urandom_range(0, (span > r.size) ? span - r.size : 0));
    end
    return r;
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_RAM_BASE:     ram_base   = val;
      REG_RAM_LENGTH:   ram_len    = val[LEN_W-1:0];
      REG_FLASH_BASE:   flash_base = val;
      REG_FLASH_LENGTH: flash_len  = val[LEN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regions(input logic [ADDR_W-1:0] rb, input logic [LEN_W-1:0] rl,
                             input logic [ADDR_W-1:0] fb, input logic [LEN_W-1:0] fl);
    write_reg(REG_RAM_BASE, rb);
    write_reg(REG_RAM_LENGTH, CFG_W'(rl));
    write_reg(REG_FLASH_BASE, fb);
    write_reg(REG_FLASH_LENGTH, CFG_W'(fl));
    cfg_we <= 1'b0;
  endtask

  // leaves s_tvalid high on return; the caller drives it again in the same step
  task automatic send_item(input guard_req_t r, input logic typed, input guard_rsp_t typed_rsp);
    guard_rsp_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_TDATA_W'({r.wdata, r.size, r.addr});
    s_tuser  <= r.op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = predict_access(r);
    pending_results.push_back(typed ? typed_rsp : predicted);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: check every beat, then decide next cycle's ready
  initial begin
    guard_rsp_t want;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result beat: expected none, actual rd=%h status=%0d",
                   $time, m_tdata, m_tuser);
        end else begin
          want = pending_results.pop_front();
          if (m_tdata !== want.rd || m_tuser !== want.st) begin
            mismatch_count++;
            $display("%0t: result mismatch: expected rd=%h status=%0d, actual rd=%h status=%0d",
                     $time, want.rd, want.st, m_tdata, m_tuser);
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    logic [ADDR_W-1:0] rnd_base;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_RAM_BASE;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = OP_CORE_READ;
    foreach (ram_img[i]) ram_img[i] = RAM_FILL;
    foreach (flash_img[i]) flash_img[i] = FLASH_FILL;
    sticky_err = 1'b0;
    ram_base   = '0;
    ram_len    = '0;
    flash_base = '0;
    flash_len  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == DIR_CFG_AT) begin
        drain();
        set_regions(32'h0000_1000, 13'd4096, 32'hFFFF_F000, 13'd4096);
      end
      send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
    end
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: set_regions(32'h0000_0000, 13'd4096, 32'h0000_1000, 13'd4096);
        // flash sits inside RAM; RAM length above the store depth
        1: set_regions(32'h2000_0000, 13'h1FFF, 32'h2000_0800, 13'd100);
        2: set_regions(32'hFFFF_F800, 13'd2048, 32'h0000_0000, 13'd0);
        3: begin
          rnd_base = $urandom;
          set_regions(rnd_base, 13'($urandom_range(1, 8191)),
                      rnd_base + 32'($urandom_range(0, 8192)), 13'($urandom_range(0, 8191)));
        end
        4: set_regions(32'h8000_0000, 13'd17, 32'h7FFF_FFFF, 13'd1);
        default: set_regions(32'h0000_0100, 13'd4095, 32'hFFFF_F000, 13'd4096);
      endcase
      if (p < 2) begin
        tx_idle_pct = 18;
        rx_idle_pct = 73;
      end else if (p < 4) begin
        tx_idle_pct = 73;
        rx_idle_pct = 18;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // long receiver stall while items keep coming: fills the block, backs up s_tready
      if (p == 1) rx_hold = RX_HOLD_CYCLES;
      repeat (ITEMS_PER_PHASE) send_item(rand_access(), 1'b0, '0);
      drain();
    end

    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
